// ===== sv/blir_pkg.sv =====
// ----------------------------------------------------------------------------
// blir_pkg
// Shared types, constants and the window classifier for the button ladder
// to IR frame block.
// ----------------------------------------------------------------------------
package blir_pkg;

  localparam int NumWindows   = 9;
  localparam int QueueDepth   = 2;
  localparam logic [3:0] NoWindow    = 4'd15;
  localparam logic [3:0] GreenButton = 4'd2;
  localparam logic [7:0] AddrReset   = 8'd66;

  // Mark codes on the result channel.
  localparam logic [1:0] MarkStart = 2'd0;
  localparam logic [1:0] MarkOne   = 2'd1;
  localparam logic [1:0] MarkZero  = 2'd2;

  // Mark positions of the last mark of each frame kind.
  localparam logic [4:0] LastIdxShort = 5'd15;
  localparam logic [4:0] LastIdxGreen = 5'd20;

  // Exclusive window bounds and per-window command codes.
  localparam logic [7:0] WinHigh [NumWindows] =
    '{8'd252, 8'd235, 8'd210, 8'd200, 8'd189, 8'd175, 8'd163, 8'd148, 8'd70};
  localparam logic [7:0] WinLow  [NumWindows] =
    '{8'd235, 8'd210, 8'd200, 8'd189, 8'd175, 8'd163, 8'd148, 8'd70, 8'd1};
  localparam logic [7:0] WinCmd  [NumWindows] =
    '{8'h4C, 8'h28, 8'h82, 8'h62, 8'hAC, 8'h2C, 8'hC8, 8'h48, 8'hCC};

  // One confirmed press, as handed from the front end to the sequencer.
  typedef struct packed {
    logic [3:0] button;
    logic [7:0] address;
  } frame_req_t;

  // Returns the window of a sample, or NoWindow when it lies in none.
  // The windows are disjoint, so the compares are independent.
  function automatic logic [3:0] classify(input logic [7:0] s);
    logic [3:0] w;
    w = NoWindow;
    for (int k = 0; k < NumWindows; k++) begin
      if ((s < WinHigh[k]) && (s > WinLow[k])) begin
        w = 4'(k);
      end
    end
    return w;
  endfunction

  // Command code of a window.
  function automatic logic [7:0] command_of(input logic [3:0] btn);
    logic [7:0] c;
    c = 8'h00;
    for (int k = 0; k < NumWindows; k++) begin
      if (btn == 4'(k)) begin
        c = WinCmd[k];
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/blir_front.sv =====
// ----------------------------------------------------------------------------
// blir_front
// Classifies ladder samples, tracks the pending press and pushes a frame
// request into the queue when a press is confirmed. Holds the address register.
// ----------------------------------------------------------------------------
module blir_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_sample,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_device_address,
  input  logic                 q_full,
  output logic                 push,
  output blir_pkg::frame_req_t push_req
);

  logic       pending_valid_r, pending_valid_nxt;
  logic [3:0] pending_button_r, pending_button_nxt;
  logic [7:0] device_address_r;
  logic       accept;
  logic [3:0] win;
  logic       confirm;

  // A request is taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign win      = blir_pkg::classify(in_sample);
  assign confirm  = accept && (win != blir_pkg::NoWindow) &&
                    pending_valid_r && (pending_button_r == win);

  // Pending press update.
  always_comb begin
    pending_valid_nxt  = pending_valid_r;
    pending_button_nxt = pending_button_r;
    if (accept) begin
      if (win == blir_pkg::NoWindow) begin
        pending_valid_nxt = 1'b0;
      end else if (confirm) begin
        pending_valid_nxt = 1'b0;
      end else begin
        pending_valid_nxt  = 1'b1;
        pending_button_nxt = win;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_valid_r  <= 1'b0;
      pending_button_r <= 4'd0;
      device_address_r <= blir_pkg::AddrReset;
    end else begin
      pending_valid_r  <= pending_valid_nxt;
      pending_button_r <= pending_button_nxt;
      if (cfg_we) begin
        device_address_r <= cfg_device_address;
      end
    end
  end

  // The address is captured with the press so the frame is self-contained.
  assign push             = confirm;
  assign push_req.button  = win;
  assign push_req.address = device_address_r;

endmodule

// ===== sv/blir_queue.sv =====
// ----------------------------------------------------------------------------
// blir_queue
// Small FIFO of confirmed presses between the front end and the sequencer.
// ----------------------------------------------------------------------------
module blir_queue #(
  parameter int DEPTH = blir_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  blir_pkg::frame_req_t push_req,
  input  logic                 pop,
  output blir_pkg::frame_req_t head,
  output logic                 empty,
  output logic                 full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  blir_pkg::frame_req_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CntFull);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/blir_seq.sv =====
// ----------------------------------------------------------------------------
// blir_seq
// Mark sequencer: walks the frame at the queue head one mark per cycle, when
// not stalled, into an output register and pops the request with its last mark.
// ----------------------------------------------------------------------------
module blir_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  blir_pkg::frame_req_t head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_mark_kind,
  output logic [3:0]           out_button,
  output logic                 out_last_mark
);

  logic [4:0]  idx_r;
  logic        out_valid_r;
  logic [1:0]  mark_kind_r;
  logic [3:0]  button_r;
  logic        last_mark_r;
  logic        advance;
  logic        emit;
  logic [19:0] bits;
  logic [4:0]  bit_pos;
  logic        is_last;
  logic [1:0]  kind;

  // Output register is free when empty or being taken.
  assign advance = !out_valid_r || !out_stall;
  assign emit    = advance && !empty;

  // Frame payload after the start mark: command, address, then zeros.
  assign bits    = {blir_pkg::command_of(head.button), head.address, 4'b0000};
  assign bit_pos = 5'd20 - idx_r;
  assign is_last = (head.button == blir_pkg::GreenButton) ?
                   (idx_r == blir_pkg::LastIdxGreen) :
                   (idx_r == blir_pkg::LastIdxShort);

  always_comb begin
    if (idx_r == '0) begin
      kind = blir_pkg::MarkStart;
    end else if (bits[bit_pos]) begin
      kind = blir_pkg::MarkOne;
    end else begin
      kind = blir_pkg::MarkZero;
    end
  end

  assign pop = emit && is_last;

  // Mark counter and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
      if (emit) begin
        idx_r <= is_last ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      mark_kind_r <= kind;
      button_r    <= head.button;
      last_mark_r <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_mark_kind = mark_kind_r;
  assign out_button    = button_r;
  assign out_last_mark = last_mark_r;

endmodule

// ===== sv/button_ladder_to_ir_frame.sv =====
// ----------------------------------------------------------------------------
// button_ladder_to_ir_frame
// Turns ladder samples into IR frames: front end, press queue, mark sequencer.
// ----------------------------------------------------------------------------
// A confirming sample pushes its press into the queue; an idle sequencer then
// loads the first mark into its output register. Throughput: one sample per
// cycle; a frame is 16 marks (21 for the green button) at one mark per cycle
// when not stalled, set by the sequencer. Samples stall only while the press
// queue is full. Reset clears the pending press, the queue and the output; address is 66.
module button_ladder_to_ir_frame #(
  parameter int QUEUE_DEPTH = blir_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_sample,
  input  logic       cfg_we,
  input  logic [7:0] cfg_device_address,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_mark_kind,
  output logic [3:0] out_button,
  output logic       out_last_mark
);

  blir_pkg::frame_req_t push_req, head;
  logic push, pop, q_full, q_empty;

  // Sample classification and press confirmation.
  blir_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .cfg_we            (cfg_we),
    .cfg_device_address(cfg_device_address),
    .q_full            (q_full),
    .push              (push),
    .push_req          (push_req)
  );

  // Queue of confirmed presses.
  blir_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_req(push_req),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // Mark generation.
  blir_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_mark_kind(out_mark_kind),
    .out_button   (out_button),
    .out_last_mark(out_last_mark)
  );

endmodule

// ===== sv/blir_checker.sv =====
// ----------------------------------------------------------------------------
// blir_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module blir_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_mark_kind,
  input logic [3:0] out_button,
  input logic       out_last_mark
);

  // A stalled request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mark_kind) &&
    $stable(out_button) && $stable(out_last_mark))
    else $error("result changed while stalled");

  // Only the three mark codes appear.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mark_kind == blir_pkg::MarkStart) ||
                  (out_mark_kind == blir_pkg::MarkOne) ||
                  (out_mark_kind == blir_pkg::MarkZero))
    else $error("bad mark code");

  // Button index stays within the nine windows.
  a_button: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_button <= 4'd8)
    else $error("bad button index");

  // A start mark never ends a frame.
  a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mark_kind == blir_pkg::MarkStart) |-> !out_last_mark)
    else $error("start mark flagged as last");

endmodule

bind button_ladder_to_ir_frame blir_checker u_blir_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_mark_kind(out_mark_kind),
  .out_button   (out_button),
  .out_last_mark(out_last_mark)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for button_ladder_to_ir_frame. Ladder samples are
// driven with random gaps, and a local tracker of the pending press builds
// the expected mark sequence of every confirmed press. Each mark taken from
// the result side is compared field by field with the oldest expected mark.
// The device address is rewritten between phases, and the mark receiver
// stalls at random and once holds off long enough to back up the samples.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit    = 300000;
  localparam int SettleCycles  = 8;
  localparam int HoldOffAfter  = 220;
  localparam int HoldOffCycles = 300;
  localparam int PhaseItems    = 26;
  localparam int MaxPrinted    = 40;

  // Boundary values, every window, a failed confirmation, a press dropped by
  // an out-of-window sample, and a repeat press right after a confirmation.
  localparam int NumDirected = 26;
  localparam logic [7:0] DirectedSamples [NumDirected] = '{
    8'd0,   8'd255, 8'd252, 8'd251, 8'd236, 8'd234, 8'd235, 8'd211, 8'd209,
    8'd201, 8'd190, 8'd199, 8'd188, 8'd176, 8'd174, 8'd164, 8'd162, 8'd149,
    8'd147, 8'd71,  8'd71,  8'd147, 8'd70,  8'd69,  8'd2,   8'd1
  };

  // One mark of an IR frame as seen on the result side.
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] button;
    logic       is_last;
  } ir_mark_t;

  // Tracks the pending press and holds the marks still owed by the block.
  class ir_frame_tracker;
    logic [7:0] address;
    bit         pending_valid;
    logic [3:0] pending_button;
    ir_mark_t   marks_due[$];
    int         mismatches;

    function new();
      address        = blir_pkg::AddrReset;
      pending_valid  = 1'b0;
      pending_button = 4'd0;
      mismatches     = 0;
    endfunction

    // Both bounds of a window are excluded.
    function logic [3:0] window_of(input logic [7:0] s);
      logic [3:0] w;
      w = blir_pkg::NoWindow;
      for (int k = 0; k < blir_pkg::NumWindows; k++) begin
        if ((s > blir_pkg::WinLow[k]) && (s < blir_pkg::WinHigh[k])) begin
          w = 4'(k);
        end
      end
      return w;
    endfunction

    function void push_mark(input logic [1:0] kind, input logic [3:0] btn);
      ir_mark_t m;
      m.kind    = kind;
      m.button  = btn;
      m.is_last = 1'b0;
      marks_due.push_back(m);
    endfunction

    // Sends the top count bits of value, most significant first.
    function void push_bits(input logic [7:0] value, input int count,
                            input logic [3:0] btn);
      for (int k = 0; k < count; k++) begin
        push_mark(value[7 - k] ? blir_pkg::MarkOne : blir_pkg::MarkZero, btn);
      end
    endfunction

    // Called for every accepted sample request.
    function void note_sample(input logic [7:0] s);
      logic [3:0] w;
      ir_mark_t   m;
      w = window_of(s);
      if (w == blir_pkg::NoWindow) begin
        pending_valid = 1'b0;
      end else if (!pending_valid || (pending_button != w)) begin
        pending_valid  = 1'b1;
        pending_button = w;
      end else begin
        pending_valid = 1'b0;
        push_mark(blir_pkg::MarkStart, w);
        push_bits(blir_pkg::WinCmd[w], 8, w);
        if (w == blir_pkg::GreenButton) begin
          push_bits(address, 8, w);
          push_bits(8'h00, 4, w);
        end else begin
          push_bits(address, 7, w);
        end
        m = marks_due.pop_back();
        m.is_last = 1'b1;
        marks_due.push_back(m);
      end
    endfunction

    task report_mismatch(input string what);
      if (mismatches < MaxPrinted) begin
        $display("MISMATCH @%0t: %s", $time, what);
      end
      mismatches++;
    endtask

    // Called for every accepted mark request.
    task check_mark(input logic [1:0] kind, input logic [3:0] btn,
                    input logic is_last);
      ir_mark_t want;
      if (marks_due.size() == 0) begin
        report_mismatch($sformatf("unexpected mark kind %0d button %0d", kind, btn));
      end else begin
        want = marks_due.pop_front();
        if (kind !== want.kind) begin
          report_mismatch($sformatf("mark_kind %0d, expected %0d (button %0d)",
                                    kind, want.kind, want.button));
        end
        if (btn !== want.button) begin
          report_mismatch($sformatf("button %0d, expected %0d", btn, want.button));
        end
        if (is_last !== want.is_last) begin
          report_mismatch($sformatf("last_mark %0b, expected %0b (button %0d)",
                                    is_last, want.is_last, want.button));
        end
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_sample;
  logic       cfg_we;
  logic [7:0] cfg_device_address;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_mark_kind;
  logic [3:0] out_button;
  logic       out_last_mark;

  ir_frame_tracker tracker = new();
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int cycle_count = 0;

  button_ladder_to_ir_frame dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .cfg_we             (cfg_we),
    .cfg_device_address (cfg_device_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mark_kind      (out_mark_kind),
    .out_button         (out_button),
    .out_last_mark      (out_last_mark)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("button_ladder_to_ir_frame regression: fail");
      $finish;
    end
  end

  // Every accepted mark request is checked against the tracker.
  always @(posedge clk) begin
    if (rst_n && (out_valid === 1'b1) && (out_stall == 1'b0)) begin
      tracker.check_mark(out_mark_kind, out_button, out_last_mark);
    end
  end

  // Mark receiver: a random stall before each mark, calm stretches with none,
  // and one long hold-off that lets the press queue fill up.
  initial begin : mark_receiver
    int  wait_cycles;
    int  marks_taken;
    bit  held;
    out_stall   = 1'b0;
    marks_taken = 0;
    held        = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && (marks_taken >= HoldOffAfter)) begin
        held        = 1'b1;
        wait_cycles = HoldOffCycles;
      end else begin
        if ($urandom_range(0, 11) == 0) rx_calm = !rx_calm;
        wait_cycles = rx_calm ? 0 : $urandom_range(0, 5);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      marks_taken++;
    end
  end

  // Offers one sample request after a random gap; returns on a falling edge.
  task automatic send_sample(input logic [7:0] s);
    int gap;
    if ($urandom_range(0, 11) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_sample(s);
    @(negedge clk);
  endtask

  // Lets every owed mark arrive, then lets the pipeline settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.marks_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    cfg_we             <= 1'b1;
    cfg_device_address <= a;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.address = a;
  endtask

  // Mostly confirming pairs from one window, the rest single noisy samples.
  task automatic run_random_phase(input int count);
    int n;
    int w;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 3) != 0) begin
        w = $urandom_range(0, blir_pkg::NumWindows - 1);
        send_sample(8'($urandom_range(blir_pkg::WinLow[w] + 1,
                                      blir_pkg::WinHigh[w] - 1)));
        send_sample(8'($urandom_range(blir_pkg::WinLow[w] + 1,
                                      blir_pkg::WinHigh[w] - 1)));
        n += 2;
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          send_sample(blir_pkg::WinHigh[$urandom_range(0, blir_pkg::NumWindows - 1)]);
        end else begin
          send_sample(8'($urandom_range(0, 255)));
        end
        n++;
      end
    end
  endtask

  initial begin : stimulus
    in_valid           = 1'b0;
    in_sample          = 8'd0;
    cfg_we             = 1'b0;
    cfg_device_address = 8'd0;
    rst_n              = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed samples under the reset address.
    foreach (DirectedSamples[i]) begin
      send_sample(DirectedSamples[i]);
    end
    settle();

    // Random phases, each under its own device address.
    write_address(8'h00);
    run_random_phase(PhaseItems);
    settle();
    write_address(8'hFF);
    run_random_phase(PhaseItems);
    settle();
    write_address(8'hA5);
    run_random_phase(PhaseItems);
    settle();
    write_address(8'($urandom_range(0, 255)));
    run_random_phase(PhaseItems);
    settle();

    if (tracker.mismatches == 0) begin
      $display("button_ladder_to_ir_frame regression: pass");
    end else begin
      $display("button_ladder_to_ir_frame regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/blir_pkg.sv
sv/blir_front.sv
sv/blir_queue.sv
sv/blir_seq.sv
sv/button_ladder_to_ir_frame.sv
sv/blir_checker.sv
verif/tb_top.sv
